[hdl/cdp_pkg.sv]
// Shared types and constants for the checked saturating decimal parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cdp_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned MAG_W = 31;
   localparam int unsigned VALUE_W = 32;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   // Saturation limits: magnitude may grow to LIMIT_DIV10 * 10 + LIMIT_LAST
   localparam logic [MAG_W-1:0] LIMIT_DIV10 = 31'd214748364;
   localparam logic [3:0] LIMIT_LAST = 4'd7;
   localparam logic signed [VALUE_W-1:0] MAX_POS = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] MIN_NEG = 32'sh8000_0000;

   // Request held in the input stage
   typedef struct packed {
      logic step;                  // request is consumed this cycle
      logic last;                  // request is the terminating NUL
      logic [CHAR_W-1:0] character;
   } cdp_step_type;

   // Result computed by the parse core for a terminating NUL
   typedef struct packed {
      logic valid_res;
      logic signed [VALUE_W-1:0] value;
   } cdp_result_type;

endpackage
`default_nettype wire

[hdl/cdp_in_stage.sv]
// Input register of the parser: holds one request and decides when it advances.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdp_in_stage (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [cdp_pkg::CHAR_W-1:0] req_character,
   input  wire logic out_free,          // result register can take a result
   output cdp_pkg::cdp_step_type stage
);

   logic vld_ff;
   logic vld_in;
   logic [cdp_pkg::CHAR_W-1:0] char_ff;
   logic last;
   logic step;
   logic load;

   assign last = (char_ff == cdp_pkg::CHAR_NUL);
   // Non-NUL characters only touch parser state; NUL needs a free result slot.
   assign step = vld_ff && (!last || out_free);
   assign req_ready = !vld_ff || step;
   assign load = req_valid && req_ready;
   assign vld_in = load || (vld_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (load) begin
         char_ff <= req_character;
      end
   end

   assign stage.step = step;
   assign stage.last = last;
   assign stage.character = char_ff;

endmodule
`default_nettype wire

[hdl/cdp_parse_core.sv]
// Parse state machine and saturating accumulator, one character per cycle whenever the input stage steps.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdp_parse_core (
   input  wire logic clock,
   input  wire logic reset,
   input  cdp_pkg::cdp_step_type stage,
   output cdp_pkg::cdp_result_type result
);

   typedef enum logic [2:0] {
      PH_LEAD  = 3'd0,
      PH_SIGN  = 3'd1,
      PH_DIG   = 3'd2,
      PH_TRAIL = 3'd3,
      PH_BAD   = 3'd4
   } phase_type;

   phase_type phase_ff, phase_in;
   logic negative_ff, negative_in;
   logic [cdp_pkg::MAG_W-1:0] magnitude_ff, magnitude_in;
   logic clipped_ff, clipped_in;

   logic [cdp_pkg::CHAR_W-1:0] c;
   logic is_digit, is_space, is_sign;
   logic [3:0] digit;
   logic over;
   logic [cdp_pkg::MAG_W+3:0] times10;
   logic [cdp_pkg::MAG_W-1:0] dig_mag;
   logic dig_clip;
   logic [cdp_pkg::VALUE_W-1:0] mag_ext;

   assign c = stage.character;
   assign is_digit = (c >= cdp_pkg::CHAR_ZERO) && (c <= cdp_pkg::CHAR_NINE);
   assign is_space = (c == cdp_pkg::CHAR_SPACE);
   assign is_sign = (c == cdp_pkg::CHAR_PLUS) || (c == cdp_pkg::CHAR_MINUS);
   assign digit = c[3:0];   // ASCII digits carry their value in the low nibble

   // mag*10 + d as two shifts and adds
   assign times10 = {1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0}
                    + {{(cdp_pkg::MAG_W){1'b0}}, digit};
   assign over = (magnitude_ff > cdp_pkg::LIMIT_DIV10) ||
                 ((magnitude_ff == cdp_pkg::LIMIT_DIV10) && (digit > cdp_pkg::LIMIT_LAST));

   always_comb begin
      dig_mag = magnitude_ff;
      dig_clip = clipped_ff;
      if (!clipped_ff) begin
         if (over) begin
            dig_clip = 1'b1;
         end else begin
            dig_mag = times10[cdp_pkg::MAG_W-1:0];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      negative_in = negative_ff;
      magnitude_in = magnitude_ff;
      clipped_in = clipped_ff;
      if (stage.step) begin
         if (stage.last) begin
            phase_in = PH_LEAD;
            negative_in = 1'b0;
            magnitude_in = '0;
            clipped_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_LEAD: begin
                  if (is_space) begin
                     phase_in = PH_LEAD;
                  end else if (is_sign) begin
                     negative_in = (c == cdp_pkg::CHAR_MINUS);
                     phase_in = PH_SIGN;
                  end else if (is_digit) begin
                     magnitude_in = dig_mag;
                     clipped_in = dig_clip;
                     phase_in = PH_DIG;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_SIGN, PH_DIG: begin
                  if (is_digit) begin
                     magnitude_in = dig_mag;
                     clipped_in = dig_clip;
                     phase_in = PH_DIG;
                  end else if (is_space) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_TRAIL: begin
                  if (!is_space) begin
                     phase_in = PH_BAD;
                  end
               end
               default: begin
                  phase_in = PH_BAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         negative_ff <= 1'b0;
         magnitude_ff <= '0;
         clipped_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         negative_ff <= negative_in;
         magnitude_ff <= magnitude_in;
         clipped_ff <= clipped_in;
      end
   end

   // Result as seen by a terminating NUL arriving now
   assign mag_ext = {1'b0, magnitude_ff};
   always_comb begin
      result.valid_res = (phase_ff == PH_DIG) || (phase_ff == PH_TRAIL);
      if (clipped_ff) begin
         result.value = negative_ff ? cdp_pkg::MIN_NEG : cdp_pkg::MAX_POS;
      end else if (negative_ff) begin
         result.value = $signed(-mag_ext);
      end else begin
         result.value = $signed(mag_ext);
      end
   end

endmodule
`default_nettype wire

[hdl/checked_saturating_decimal_parser.sv]
// Top level of the checked saturating decimal parser: input stage, parse core,
// result register. Depends on cdp_pkg, cdp_in_stage and cdp_parse_core.
//
// Usage:
//   req_* carries one character per request (valid/ready). Any number of
//   leading spaces, an optional '+' or '-', digits, then only spaces form a
//   well-formed integer (a sign then spaces too, as 0). A NUL character
//   ends the string. rsp_* carries one result per NUL: rsp_valid_res says
//   whether the string was well formed, rsp_value is the signed value
//   saturated to 32 bits. Non-NUL characters produce no response.
// Timing:
//   A request is captured in the input register and updates the parser on
//   the next edge, unless it is a NUL held by a stall; for a NUL that same
//   edge loads the response register. Throughput is one character per cycle
//   while no NUL is held; the per-character update is one multiply-by-10
//   add and compare in the parse core.
// Stall:
//   While a response waits on rsp_ready, non-NUL characters keep flowing.
//   A NUL behind an untaken response holds in the input register, and
//   req_ready drops until the response is taken.
// Reset:
//   Synchronous, active high; parser returns to leading-space state and both
//   channels empty. After each NUL the parser clears for the next string.
`timescale 1ns / 1ps
`default_nettype none
module checked_saturating_decimal_parser (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_character,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_valid_res,
   output logic signed [31:0] rsp_value
);

   cdp_pkg::cdp_step_type stage;
   cdp_pkg::cdp_result_type result;

   logic out_free;
   logic rsp_load;
   logic rsp_vld_ff, rsp_vld_in;
   logic rsp_valid_res_ff;
   logic signed [cdp_pkg::VALUE_W-1:0] rsp_value_ff;

   // result slot is free when empty or being drained this cycle
   assign out_free = !rsp_vld_ff || rsp_ready;

   cdp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_character (req_character),
      .out_free      (out_free),
      .stage         (stage)
   );

   cdp_parse_core u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .result (result)
   );

   // Response register
   assign rsp_load = stage.step && stage.last;
   assign rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (rsp_load) begin
         rsp_valid_res_ff <= result.valid_res;
         rsp_value_ff <= result.value;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_value = rsp_value_ff;

   // A consumed NUL always lands in the response register.
   a_nul_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (stage.step && stage.last) |=> rsp_vld_ff)
      else $error("terminating NUL did not produce a response");

   // A NUL never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ready && stage.last) |-> !stage.step)
      else $error("pending response overwritten");

   // Non-NUL characters never stall on the response side.
   a_char_flows: assert property (@(posedge clock) disable iff (reset)
      (!stage.last) |-> req_ready)
      else $error("input stalled behind a non-terminating character");

endmodule
`default_nettype wire

[test/tb_checked_saturating_decimal_parser.sv]
// Self-checking testbench for checked_saturating_decimal_parser: directed and
// random character streams with random stalls on both channels.
// Depends on cdp_pkg and the checked_saturating_decimal_parser RTL.
`timescale 1ns / 1ps
module tb_checked_saturating_decimal_parser;
   import cdp_pkg::*;

   // Scanner phases of the predictor; codes 5..7 are never reached
   typedef enum logic [2:0] {
      SCAN_LEAD,
      SCAN_SIGN,
      SCAN_DIGITS,
      SCAN_TRAIL,
      SCAN_BAD
   } scan_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CHAR_W-1:0] req_character = CHAR_NUL;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_valid_res;
   logic signed [VALUE_W-1:0] rsp_value;

   checked_saturating_decimal_parser DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_character(req_character),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_valid_res(rsp_valid_res),
      .rsp_value(rsp_value)
   );

   initial forever #5 clock = ~clock;

   // Hard stop. Worst case is roughly 800 requests each behind the longest
   // gap plus ~150 responses each behind the longest stall: well under 1 ms.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Characters waiting to be driven, and results the parser owes us
   logic [CHAR_W-1:0] char_queue[$];
   cdp_result_type parsed_results[$];
   int unsigned error_count = 0;

   // Predictor state; matches the block's reset state
   scan_phase_type scan_phase = SCAN_LEAD;
   logic scan_negative = 1'b0;
   logic [MAG_W-1:0] scan_magnitude = '0;
   logic scan_clipped = 1'b0;

   // --------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------

   // Accumulate one decimal digit; once past the 32-bit limit, the
   // magnitude freezes and the clipped flag sticks until the string ends.
   task automatic add_digit(input logic [3:0] digit);
      if (scan_clipped)
         return;
      if (scan_magnitude > LIMIT_DIV10 ||
          (scan_magnitude == LIMIT_DIV10 && digit > LIMIT_LAST)) begin
         scan_clipped = 1'b1;
         return;
      end
      scan_magnitude = scan_magnitude * 31'd10 + MAG_W'(digit);
   endtask

   // Advance the scanner by one accepted request; a NUL queues the result
   // and returns the scanner to its start state.
   task automatic scan_character(input logic [CHAR_W-1:0] ch);
      logic is_digit;
      logic is_space;
      logic is_sign;
      cdp_result_type res;
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      is_space = (ch == CHAR_SPACE);
      is_sign = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
      if (ch == CHAR_NUL) begin
         // a string that reached digits or the trailing phase is well formed; sign + spaces
         // lands in the trailing phase and counts as a valid zero
         res.valid_res = (scan_phase == SCAN_DIGITS) || (scan_phase == SCAN_TRAIL);
         if (scan_clipped)
            res.value = scan_negative ? MIN_NEG : MAX_POS;
         else if (scan_negative)
            res.value = -$signed({1'b0, scan_magnitude});
         else
            res.value = $signed({1'b0, scan_magnitude});
         parsed_results.push_back(res);
         scan_phase = SCAN_LEAD;
         scan_negative = 1'b0;
         scan_magnitude = '0;
         scan_clipped = 1'b0;
         return;
      end
      case (scan_phase)
         SCAN_LEAD: begin
            if (is_sign) begin
               scan_negative = (ch == CHAR_MINUS);
               scan_phase = SCAN_SIGN;
            end else if (is_digit) begin
               add_digit(ch[3:0]);
               scan_phase = SCAN_DIGITS;
            end else if (!is_space) begin
               scan_phase = SCAN_BAD;
            end
         end
         SCAN_SIGN, SCAN_DIGITS: begin
            if (is_digit) begin
               add_digit(ch[3:0]);
               scan_phase = SCAN_DIGITS;
            end else if (is_space) begin
               scan_phase = SCAN_TRAIL;
            end else begin
               scan_phase = SCAN_BAD;
            end
         end
         SCAN_TRAIL: begin
            if (!is_space)
               scan_phase = SCAN_BAD;
         end
         default: scan_phase = SCAN_BAD;
      endcase
   endtask

   task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                                input logic signed [31:0] want);
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Length of a stall: mostly none or short, now and then long.
   // Quiet windows force back-to-back traffic.
   function automatic int unsigned pick_gap(input logic quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic queue_string(input string s);
      foreach (s[i])
         char_queue.push_back(s[i]);
      char_queue.push_back(CHAR_NUL);
   endtask

   // --------------------------------------------------------------------
   // Drivers (falling edge)
   // --------------------------------------------------------------------
   logic req_taken = 1'b0;       // request accepted at the last rising edge
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   int unsigned cycle_count = 0;
   logic quiet;

   // Recurring quiet stretches with no idling on either side
   assign quiet = (cycle_count % 2500) < 500;

   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // only move on once the current request is gone
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (char_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_character <= char_queue.pop_front();
            req_gap <= pick_gap(quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, independent of rsp_valid
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 25)
            rsp_hold <= pick_gap(quiet);
      end
   end

   // --------------------------------------------------------------------
   // Monitor (rising edge): predict on request, check on response
   // --------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      cdp_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_results.size() == 0) begin
               flag_mismatch("response with none expected", rsp_value, 0);
            end else begin
               want = parsed_results.pop_front();
               if (rsp_valid_res !== want.valid_res)
                  flag_mismatch("valid_res", rsp_valid_res, want.valid_res);
               if (rsp_value !== want.value)
                  flag_mismatch("value", rsp_value, want.value);
            end
         end
         if (req_valid && req_ready)
            scan_character(req_character);
         req_taken <= req_valid && req_ready;
      end
   end

   // --------------------------------------------------------------------
   // Stimulus and end of test
   // --------------------------------------------------------------------
   initial begin : stimulus
      logic [CHAR_W-1:0] text[$];
      string limit_prefix;
      int unsigned kind;
      int unsigned shape;
      limit_prefix = "214748364";

      // Directed: empty, spaces only, bare sign, sign then spaces (valid 0),
      // leading zero, digit after a trailing space, double sign, and the
      // extreme non-NUL codes as stray characters.
      queue_string("");
      queue_string("  ");
      queue_string("-");
      queue_string("+ ");
      queue_string("-9 ");
      queue_string("07");
      queue_string("1 2");
      queue_string("+-");
      char_queue.push_back(8'hFF);
      char_queue.push_back(CHAR_NUL);
      char_queue.push_back(8'h01);
      char_queue.push_back(CHAR_NUL);

      // Random strings, mostly well formed so the digit and trailing
      // phases and saturation get real coverage
      while (char_queue.size() < 730) begin
         text.delete();
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            repeat ($urandom_range(0, 3)) text.push_back(CHAR_SPACE);
            case ($urandom_range(0, 2))
               1: text.push_back(CHAR_PLUS);
               2: text.push_back(CHAR_MINUS);
               default: ;
            endcase
            shape = $urandom_range(0, 99);
            if (shape < 60) begin
               repeat ($urandom_range(1, 5))
                  text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end else if (shape < 80) begin
               repeat ($urandom_range(6, 12))
                  text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end else if (shape < 95) begin
               // straddle the saturation point, sometimes with more digits
               foreach (limit_prefix[i])
                  text.push_back(limit_prefix[i]);
               repeat ($urandom_range(1, 3))
                  text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2)) text.push_back(CHAR_SPACE);
            // about a fifth of these get one character broken
            if (kind >= 55) begin
               if (text.size() == 0)
                  text.push_back(8'($urandom_range(1, 255)));
               else
                  text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
            end
         end else if (kind < 80) begin
            // pure noise, any non-NUL code
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
         end else begin
            // jumble of the meaningful characters
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0: text.push_back(CHAR_SPACE);
                  1: text.push_back(CHAR_PLUS);
                  2: text.push_back(CHAR_MINUS);
                  default: text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               endcase
            end
         end
         foreach (text[i])
            char_queue.push_back(text[i]);
         char_queue.push_back(CHAR_NUL);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests in, then all results out, then a few quiet cycles to
      // catch anything extra
      while (char_queue.size() != 0 || req_valid)
         @(posedge clock);
      while (parsed_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
